FILE: hdl/tt16_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables for the token text to utf16 block
// used by tt16_front, tt16_queue, tt16_back and token_text_to_utf16
package tt16_pkg;

  localparam int unsigned MaxPendingSpaces = 255;
  localparam logic [7:0] SpaceCap = 8'(MaxPendingSpaces > 255 ? 255 : MaxPendingSpaces);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_TOKEN
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] code_unit;
    logic [6:0]  token_index;
    logic        final_byte;
  } work_t;

  typedef struct packed {
    logic [7:0]  spaces_before;
    logic [15:0] code_unit;
    logic        has_char;
    logic        end_of_text;
  } result_t;

  function automatic logic [15:0] block_glyph(input logic [3:0] idx);
    logic [15:0] g;
    begin
      case (idx)
        4'h0: g = 16'h0020;
        4'h1: g = 16'h259d;
        4'h2: g = 16'h2598;
        4'h3: g = 16'h2580;
        4'h4: g = 16'h2597;
        4'h5: g = 16'h2590;
        4'h6: g = 16'h259a;
        4'h7: g = 16'h259c;
        4'h8: g = 16'h2596;
        4'h9: g = 16'h259e;
        4'ha: g = 16'h258c;
        4'hb: g = 16'h259b;
        4'hc: g = 16'h2584;
        4'hd: g = 16'h259f;
        4'he: g = 16'h2599;
        default: g = 16'h2588;
      endcase
      return g;
    end
  endfunction

  // keyword text, 9 chars, first char in the top byte, zero padded
  function automatic logic [71:0] keyword_text(input logic [6:0] idx);
    logic [71:0] t;
    begin
      case (idx)
        7'd0: t = {"RND", 48'h0};
        7'd1: t = {"INKEY$", 24'h0};
        7'd2: t = {"PI", 56'h0};
        7'd3: t = {"FN", 56'h0};
        7'd4: t = {"POINT", 32'h0};
        7'd5: t = {"SCREEN$", 16'h0};
        7'd6: t = {"ATTR", 40'h0};
        7'd7: t = {"AT", 56'h0};
        7'd8: t = {"TAB", 48'h0};
        7'd9: t = {"VAL$", 40'h0};
        7'd10: t = {"CODE", 40'h0};
        7'd11: t = {"VAL", 48'h0};
        7'd12: t = {"LEN", 48'h0};
        7'd13: t = {"SIN", 48'h0};
        7'd14: t = {"COS", 48'h0};
        7'd15: t = {"TAN", 48'h0};
        7'd16: t = {"ASN", 48'h0};
        7'd17: t = {"ACS", 48'h0};
        7'd18: t = {"ATN", 48'h0};
        7'd19: t = {"LN", 56'h0};
        7'd20: t = {"EXP", 48'h0};
        7'd21: t = {"INT", 48'h0};
        7'd22: t = {"SQR", 48'h0};
        7'd23: t = {"SGN", 48'h0};
        7'd24: t = {"ABS", 48'h0};
        7'd25: t = {"PEEK", 40'h0};
        7'd26: t = {"IN", 56'h0};
        7'd27: t = {"USR", 48'h0};
        7'd28: t = {"STR$", 40'h0};
        7'd29: t = {"CHR$", 40'h0};
        7'd30: t = {"NOT", 48'h0};
        7'd31: t = {"BIN", 48'h0};
        7'd32: t = {"OR", 56'h0};
        7'd33: t = {"AND", 48'h0};
        7'd34: t = {"<=", 56'h0};
        7'd35: t = {">=", 56'h0};
        7'd36: t = {"<>", 56'h0};
        7'd37: t = {"LINE", 40'h0};
        7'd38: t = {"THEN", 40'h0};
        7'd39: t = {"TO", 56'h0};
        7'd40: t = {"STEP", 40'h0};
        7'd41: t = {"DEF FN", 24'h0};
        7'd42: t = {"CAT", 48'h0};
        7'd43: t = {"FORMAT", 24'h0};
        7'd44: t = {"MOVE", 40'h0};
        7'd45: t = {"ERASE", 32'h0};
        7'd46: t = {"OPEN #", 24'h0};
        7'd47: t = {"CLOSE #", 16'h0};
        7'd48: t = {"MERGE", 32'h0};
        7'd49: t = {"VERIFY", 24'h0};
        7'd50: t = {"BEEP", 40'h0};
        7'd51: t = {"CIRCLE", 24'h0};
        7'd52: t = {"INK", 48'h0};
        7'd53: t = {"PAPER", 32'h0};
        7'd54: t = {"FLASH", 32'h0};
        7'd55: t = {"BRIGHT", 24'h0};
        7'd56: t = {"INVERSE", 16'h0};
        7'd57: t = {"OVER", 40'h0};
        7'd58: t = {"OUT", 48'h0};
        7'd59: t = {"LPRINT", 24'h0};
        7'd60: t = {"LLIST", 32'h0};
        7'd61: t = {"STOP", 40'h0};
        7'd62: t = {"READ", 40'h0};
        7'd63: t = {"DATA", 40'h0};
        7'd64: t = {"RESTORE", 16'h0};
        7'd65: t = {"NEW", 48'h0};
        7'd66: t = {"BORDER", 24'h0};
        7'd67: t = {"CONTINUE", 8'h0};
        7'd68: t = {"DIM", 48'h0};
        7'd69: t = {"REM", 48'h0};
        7'd70: t = {"FOR", 48'h0};
        7'd71: t = {"GO TO", 32'h0};
        7'd72: t = {"GO SUB", 24'h0};
        7'd73: t = {"INPUT", 32'h0};
        7'd74: t = {"LOAD", 40'h0};
        7'd75: t = {"LIST", 40'h0};
        7'd76: t = {"LET", 48'h0};
        7'd77: t = {"PAUSE", 32'h0};
        7'd78: t = {"NEXT", 40'h0};
        7'd79: t = {"POKE", 40'h0};
        7'd80: t = {"PRINT", 32'h0};
        7'd81: t = {"PLOT", 40'h0};
        7'd82: t = {"RUN", 48'h0};
        7'd83: t = {"SAVE", 40'h0};
        7'd84: t = {"RANDOMIZE"};
        7'd85: t = {"IF", 56'h0};
        7'd86: t = {"CLS", 48'h0};
        7'd87: t = {"DRAW", 40'h0};
        7'd88: t = {"CLEAR", 32'h0};
        7'd89: t = {"RETURN", 24'h0};
        default: t = {"COPY", 40'h0};
      endcase
      return t;
    end
  endfunction

endpackage

FILE: hdl/token_text_to_utf16.sv
`timescale 1ns / 1ps
// top level of the tokenized text to utf16 converter
// depends on tt16_pkg, tt16_front, tt16_queue, tt16_back
//
// slave channel s_axis: one text byte per word, tlast marks the last byte.
// master channel m_axis: one utf16 code unit per word with the count of
// spaces to place before it; tuser says whether it is a character, and
// tlast marks the end-of-text terminator.
// the front end classifies a byte in the cycle it is taken and pushes it
// into a two-entry queue; the back end makes at most one result per cycle
// while the output is free. a character byte is registered in the queue
// slot, then in the result register. plain characters and dropped control
// codes go at one byte per cycle while the output is free; a keyword takes a
// step per char plus a leading and a trailing pad step, and a final byte one
// more step for the terminator, so the input stalls once the queue is full.
// spaces never appear as words: they are counted and attached to the next
// character, and trailing spaces are dropped at end of text.
// rst clears control state; a result waiting on m_axis_tready holds, the
// queue stops draining, and s_axis_tready drops once the queue fills.
module token_text_to_utf16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] spaces_before, [23:8] code_unit
  output logic        m_axis_tuser,   // [0] has_char
  output logic        m_axis_tlast
);

  tt16_pkg::work_t   fe_work;
  logic              fe_valid;
  logic              fe_ready;
  tt16_pkg::work_t   q_work;
  logic              q_valid;
  logic              q_ready;
  tt16_pkg::result_t res;

  tt16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (s_axis_tdata),
    .final_byte (s_axis_tlast),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .work       (fe_work),
    .work_valid (fe_valid),
    .work_ready (fe_ready)
  );

  tt16_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (fe_work),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .rd_data  (q_work),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  tt16_back u_back (
    .clk          (clk),
    .rst          (rst),
    .work         (q_work),
    .work_valid   (q_valid),
    .work_ready   (q_ready),
    .result       (res),
    .result_valid (m_axis_tvalid),
    .result_ready (m_axis_tready)
  );

  assign m_axis_tdata = {res.code_unit, res.spaces_before};
  assign m_axis_tuser = res.has_char;
  assign m_axis_tlast = res.end_of_text;

endmodule

FILE: hdl/tt16_front.sv
`timescale 1ns / 1ps
// front end: accepts text bytes, drops control codes and their arguments,
// maps single characters and classifies tokens; depends on tt16_pkg
module tt16_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      text_byte,
  input  logic            final_byte,
  input  logic            in_valid,
  output logic            in_ready,
  output tt16_pkg::work_t work,
  output logic            work_valid,
  input  logic            work_ready
);

  logic [1:0] bytes_to_skip;
  logic [1:0] bytes_to_skip_next;
  logic       take;

  assign in_ready   = work_ready;
  assign work_valid = in_valid;
  assign take       = in_valid && work_ready;

  always_comb begin
    work = '0;
    work.kind = tt16_pkg::KIND_NONE;
    work.final_byte = final_byte;
    work.token_index = 7'(8'(text_byte - 8'ha5));
    bytes_to_skip_next = bytes_to_skip;
    if (bytes_to_skip != 2'd0) begin
      bytes_to_skip_next = bytes_to_skip - 2'd1;
    end else if (text_byte < 8'h20) begin
      if (text_byte >= 8'h10 && text_byte <= 8'h15) begin
        bytes_to_skip_next = 2'd1;
      end else if (text_byte == 8'h16 || text_byte == 8'h17) begin
        bytes_to_skip_next = 2'd2;
      end
    end else if (text_byte < 8'h80) begin
      work.kind = tt16_pkg::KIND_CHAR;
      case (text_byte)
        8'h5e: work.code_unit = 16'h2191;
        8'h60: work.code_unit = 16'h00a3;
        8'h7f: work.code_unit = 16'h00a9;
        default: work.code_unit = {8'h00, text_byte};
      endcase
    end else if (text_byte < 8'h90) begin
      work.kind = tt16_pkg::KIND_CHAR;
      work.code_unit = tt16_pkg::block_glyph(text_byte[3:0]);
    end else if (text_byte < 8'ha5) begin
      work.kind = tt16_pkg::KIND_CHAR;
      work.code_unit = 16'h25a9;
    end else begin
      work.kind = tt16_pkg::KIND_TOKEN;
    end
    if (final_byte) begin
      bytes_to_skip_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_to_skip <= 2'd0;
    end else if (take) begin
      bytes_to_skip <= bytes_to_skip_next;
    end
  end

endmodule

FILE: hdl/tt16_queue.sv
`timescale 1ns / 1ps
// short fifo of classified words between front and back end
// depends on tt16_pkg
module tt16_queue (
  input  logic            clk,
  input  logic            rst,
  input  tt16_pkg::work_t wr_data,
  input  logic            wr_valid,
  output logic            wr_ready,
  output tt16_pkg::work_t rd_data,
  output logic            rd_valid,
  input  logic            rd_ready
);

  localparam int unsigned AddrW = $clog2(tt16_pkg::QueueDepth);

  tt16_pkg::work_t slots [tt16_pkg::QueueDepth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [AddrW:0]   count;
  logic             push;
  logic             pop;

  assign wr_ready = count != (AddrW+1)'(tt16_pkg::QueueDepth);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(tt16_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(tt16_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AddrW+1)'(push) - (AddrW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (AddrW+1)'(tt16_pkg::QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !push) |=> !rd_valid)
    else $error("queue shows data while empty");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

FILE: hdl/tt16_back.sv
`timescale 1ns / 1ps
// back end: space trimming and keyword expansion, at most one result per
// cycle while the output is free, with an output register; depends on tt16_pkg
module tt16_back (
  input  logic              clk,
  input  logic              rst,
  input  tt16_pkg::work_t   work,
  input  logic              work_valid,
  output logic              work_ready,
  output tt16_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);

  // step 0 is the leading pad, 1..9 keyword chars, 10 trailing pad, 11 terminator
  logic [3:0]  step;
  logic [3:0]  step_next;
  logic        seen_visible_char;
  logic        seen_next;
  logic [7:0]  pending_spaces;
  logic [7:0]  pending_next;
  logic        out_free;
  logic        emit;
  logic        done;
  logic [15:0] cu;
  logic        is_char;
  logic [71:0] kw;
  logic [7:0]  kw_char;
  tt16_pkg::result_t res_next;

  assign out_free = !result_valid || result_ready;
  assign kw       = tt16_pkg::keyword_text(work.token_index);
  assign kw_char  = (step >= 4'd1 && step <= 4'd9) ? kw[8*(9-32'(step)) +: 8] : 8'h00;

  always_comb begin
    step_next    = step;
    seen_next    = seen_visible_char;
    pending_next = pending_spaces;
    emit         = 1'b0;
    done         = 1'b0;
    res_next     = '0;
    cu           = work.code_unit;
    is_char      = 1'b0;
    if (work_valid && out_free) begin
      if (step == 4'd11) begin
        emit = 1'b1;
        res_next.end_of_text = 1'b1;
        done = 1'b1;
      end else if (work.kind == tt16_pkg::KIND_CHAR) begin
        is_char = 1'b1;
        done = !work.final_byte;
        step_next = 4'd11;
      end else if (work.kind == tt16_pkg::KIND_TOKEN) begin
        if (step == 4'd0) begin
          if (seen_visible_char && pending_spaces == 8'd0) begin
            pending_next = 8'd1;
          end
          step_next = 4'd1;
        end else if (step == 4'd10 || kw_char == 8'h00) begin
          if (seen_visible_char && pending_spaces < tt16_pkg::SpaceCap) begin
            pending_next = pending_spaces + 8'd1;
          end
          done = !work.final_byte;
          step_next = 4'd11;
        end else begin
          is_char = 1'b1;
          cu = {8'h00, kw_char};
          step_next = step + 4'd1;
        end
      end else begin
        done = !work.final_byte;
        step_next = 4'd11;
      end
      if (is_char) begin
        if (cu == 16'h0020) begin
          if (seen_visible_char && pending_spaces < tt16_pkg::SpaceCap) begin
            pending_next = pending_spaces + 8'd1;
          end
        end else begin
          emit = 1'b1;
          res_next.spaces_before = pending_spaces;
          res_next.code_unit = cu;
          res_next.has_char = 1'b1;
          pending_next = 8'd0;
          seen_next = 1'b1;
        end
      end
      if (done) begin
        step_next = 4'd0;
        if (step == 4'd11) begin
          seen_next = 1'b0;
          pending_next = 8'd0;
        end
      end
    end
  end

  assign work_ready = work_valid && out_free && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 4'd0;
      seen_visible_char <= 1'b0;
      pending_spaces <= 8'd0;
      result_valid <= 1'b0;
    end else begin
      step <= step_next;
      seen_visible_char <= seen_next;
      pending_spaces <= pending_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid && $stable(result))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.end_of_text) |-> result.spaces_before == 8'd0)
    else $error("terminator carries spaces");
  assert property (@(posedge clk) disable iff (rst)
    (emit && res_next.end_of_text) |=> !seen_visible_char && pending_spaces == 8'd0)
    else $error("state not cleared after end of text");

endmodule
